[rtl/frdu_pkg.sv]
// Package for the repair trigger decider: field widths, register indexes,
// sequencer states and the request/response words of the shared divider.
// No dependencies.
package frdu_pkg;

    localparam int WEndW    = 32;
    localparam int WLenW    = 16;
    localparam int InflW    = 16;
    localparam int LossW    = 20;
    localparam int ScaleW   = 20;
    localparam int CountW   = 16;
    localparam int LimitW   = 32;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 20;

    // Shared divider: left-aligned dividend, one quotient bit per cycle
    localparam int DivDW   = 52;
    localparam int DivSW   = 20;
    localparam int DivCntW = 6;

    localparam logic [DivCntW-1:0] STEPS_EXPECTED = 6'd36;
    localparam logic [DivCntW-1:0] STEPS_RATIO    = 6'd20;
    localparam logic [DivCntW-1:0] STEPS_SPREAD   = 6'd52;

    localparam logic [CfgIdxW-1:0] CFG_LOSS_GRANULARITY = 4'd0;
    localparam logic [CfgIdxW-1:0] CFG_FIXED_SCALE      = 4'd1;

    localparam logic [ScaleW-1:0] SCALE_RESET = 20'd1000000;

    typedef struct packed {
        logic [WEndW-1:0] window_end;
        logic [WLenW-1:0] window_len;
        logic [InflW-1:0] repairs_in_flight;
        logic [LossW-1:0] uniform_loss;
        logic [LossW-1:0] burst_enter_p;
        logic [LossW-1:0] burst_leave_r;
        logic             flow_blocked;
    } frdu_item_t;

    typedef struct packed {
        logic               start;
        logic [DivDW-1:0]   dividend;
        logic [DivSW-1:0]   divisor;
        logic [DivCntW-1:0] steps;
    } frdu_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DivDW-1:0] quotient;
    } frdu_div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_EXP,
        S_DIV_GAP,
        S_DIV_BURST,
        S_DIV_SPR,
        S_FINISH
    } frdu_state_t;

    // Zero acts as one wherever a value is used as a divisor
    function automatic logic [DivSW-1:0] at_least_one(input logic [DivSW-1:0] v);
        at_least_one = (v == '0) ? DivSW'(1) : v;
    endfunction

endpackage

[rtl/frdu_if.sv]
// Channel interfaces of the repair trigger decider: input item, result and
// configuration write. Depends on frdu_pkg.
interface frdu_item_if import frdu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [WEndW-1:0] window_end;
    logic [WLenW-1:0] window_len;
    logic [InflW-1:0] repairs_in_flight;
    logic [LossW-1:0] uniform_loss;
    logic [LossW-1:0] burst_enter_p;
    logic [LossW-1:0] burst_leave_r;
    logic             flow_blocked;

    modport source (
        output valid, window_end, window_len, repairs_in_flight,
               uniform_loss, burst_enter_p, burst_leave_r, flow_blocked,
        input  ready
    );
    modport sink (
        input  valid, window_end, window_len, repairs_in_flight,
               uniform_loss, burst_enter_p, burst_leave_r, flow_blocked,
        output ready
    );
endinterface

interface frdu_result_if ();
    logic valid;
    logic ready;
    logic send_repair;

    modport source (output valid, send_repair, input ready);
    modport sink (input valid, send_repair, output ready);
endinterface

interface frdu_cfg_if import frdu_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/frdu_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on frdu_pkg.
module frdu_div
    import frdu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  frdu_div_req_t req,
    output frdu_div_rsp_t rsp
);

    logic [DivDW-1:0]   quo_reg, quo_next;
    logic [DivSW-1:0]   rem_reg, rem_next;
    logic [DivSW-1:0]   dsr_reg, dsr_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic [DivSW:0] trial;
    logic [DivSW:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DivDW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
            cnt_next = req.steps;
        end
        else if (cnt_reg != '0)
        begin
            // shift in one dividend bit, subtract where the divisor fits
            quo_next  = {quo_reg[DivDW-2:0], fits};
            rem_next  = fits ? diff[DivSW-1:0] : trial[DivSW-1:0];
            cnt_next  = cnt_reg - DivCntW'(1);
            done_next = (cnt_reg == DivCntW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/frdu_seq.sv]
// Sequencer of the repair trigger decider: holds the protection state,
// the shared multiplier, and steps the shared divider. Depends on frdu_pkg.
module frdu_seq
    import frdu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  frdu_item_t        item,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [ScaleW-1:0] gran_eff,
    input  logic [ScaleW-1:0] fscale_eff,
    input  logic [ScaleW-1:0] fscale_raw,
    input  logic              res_free,
    output logic              res_load,
    output logic              res_send,
    output frdu_div_req_t     div_req,
    input  frdu_div_rsp_t     div_rsp
);

    frdu_state_t       state_reg, state_next;
    frdu_item_t        item_reg, item_next;
    logic [WEndW-1:0]  unprot_reg, unprot_next;
    logic [LossW-1:0]  burst_reg, burst_next;
    logic              send_reg, send_next;
    logic [WEndW-1:0]  mark_reg, mark_next;
    logic [CountW-1:0] rfm_reg, rfm_next;
    logic [LimitW-1:0] limit_reg, limit_next;

    // shared multiplier: expected losses on accept, spread later
    logic [WEndW-1:0] mul_a;
    logic [LossW-1:0] mul_b;
    logic [DivDW-1:0] mul_prod;

    logic [35:0]       expected;
    logic [35:0]       expected1;
    logic [36:0]       budget;
    logic              over_budget;
    logic              refuse;
    logic [WLenW-1:0]  gap;
    logic              unprot_zero;
    logic              protect;
    logic [InflW-1:0]  min_count;
    logic [DivDW-1:0]  max_term;
    logic [DivDW:0]    lim_wide;

    assign mul_a    = (state_reg == S_IDLE) ? WEndW'(item.window_len) : unprot_reg;
    assign mul_b    = (state_reg == S_IDLE) ? item.uniform_loss : item_reg.uniform_loss;
    assign mul_prod = mul_a * mul_b;

    assign unprot_zero = (unprot_reg == '0);

    assign expected    = div_rsp.quotient[35:0];
    assign expected1   = (expected == '0) ? 36'd1 : expected;
    assign budget      = {expected1, 1'b0};
    assign over_budget = {21'd0, item_reg.repairs_in_flight} >= budget;
    assign refuse      = item_reg.flow_blocked
                         ? (unprot_zero && ({16'd0, rfm_reg} >= limit_reg) && over_budget)
                         : over_budget;

    assign gap     = (div_rsp.quotient < DivDW'(item_reg.window_len))
                     ? div_rsp.quotient[WLenW-1:0] : item_reg.window_len;
    assign protect = item_reg.flow_blocked || unprot_zero
                     || (unprot_reg >= {16'd0, gap});

    assign min_count = (item_reg.repairs_in_flight < rfm_reg)
                       ? item_reg.repairs_in_flight : rfm_reg;

    assign max_term = (div_rsp.quotient > DivDW'(burst_reg))
                      ? div_rsp.quotient : DivDW'(burst_reg);
    assign lim_wide = {1'b0, max_term} + (DivDW+1)'(1);

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        unprot_next = unprot_reg;
        burst_next  = burst_reg;
        send_next   = send_reg;
        mark_next   = mark_reg;
        rfm_next    = rfm_reg;
        limit_next  = limit_reg;
        div_req     = '0;
        item_ready  = 1'b0;
        res_load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    item_next        = item;
                    unprot_next      = item.window_end - mark_reg;
                    div_req.start    = 1'b1;
                    div_req.dividend = {mul_prod[35:0], 16'd0};
                    div_req.divisor  = gran_eff;
                    div_req.steps    = STEPS_EXPECTED;
                    state_next       = S_DIV_EXP;
                end
            end
            S_DIV_EXP:
            begin
                if (div_rsp.done)
                begin
                    if (refuse)
                    begin
                        send_next  = 1'b0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {gran_eff, 32'd0};
                        div_req.divisor  = at_least_one(item_reg.burst_enter_p);
                        div_req.steps    = STEPS_RATIO;
                        state_next       = S_DIV_GAP;
                    end
                end
            end
            S_DIV_GAP:
            begin
                if (div_rsp.done)
                begin
                    if (!protect)
                    begin
                        send_next  = 1'b0;
                        state_next = S_FINISH;
                    end
                    else if (unprot_zero)
                    begin
                        // same mark: count up, or cancel at the limit
                        if (item_reg.flow_blocked || ({16'd0, min_count} < limit_reg))
                        begin
                            send_next = 1'b1;
                            if (rfm_reg != '1)
                            begin
                                rfm_next = rfm_reg + CountW'(1);
                            end
                        end
                        else
                        begin
                            send_next = 1'b0;
                        end
                        state_next = S_FINISH;
                    end
                    else if (item_reg.burst_leave_r == fscale_raw)
                    begin
                        burst_next       = '0;
                        div_req.start    = 1'b1;
                        div_req.dividend = mul_prod;
                        div_req.divisor  = fscale_eff;
                        div_req.steps    = STEPS_SPREAD;
                        state_next       = S_DIV_SPR;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {gran_eff, 32'd0};
                        div_req.divisor  = at_least_one(item_reg.burst_leave_r);
                        div_req.steps    = STEPS_RATIO;
                        state_next       = S_DIV_BURST;
                    end
                end
            end
            S_DIV_BURST:
            begin
                if (div_rsp.done)
                begin
                    burst_next       = div_rsp.quotient[LossW-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_prod;
                    div_req.divisor  = fscale_eff;
                    div_req.steps    = STEPS_SPREAD;
                    state_next       = S_DIV_SPR;
                end
            end
            S_DIV_SPR:
            begin
                if (div_rsp.done)
                begin
                    // restart protection at the new window end
                    limit_next = (lim_wide[DivDW:LimitW] != '0)
                                 ? '1 : lim_wide[LimitW-1:0];
                    rfm_next   = CountW'(1);
                    mark_next  = item_reg.window_end;
                    send_next  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_send = send_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mark_reg  <= '0;
            rfm_reg   <= '0;
            limit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mark_reg  <= mark_next;
            rfm_reg   <= rfm_next;
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        unprot_reg <= unprot_next;
        burst_reg  <= burst_next;
        send_reg   <= send_next;
    end

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_EXP || state_reg == S_DIV_GAP
                          || state_reg == S_DIV_BURST || state_reg == S_DIV_SPR))
        else $error("divider finished outside a wait state");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_SPR && div_rsp.done)
        |=> (rfm_reg == CountW'(1) && mark_reg == $past(item_reg.window_end)))
        else $error("protection restart did not set count and mark");

    a_mark_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(mark_reg) |-> $past(state_reg == S_DIV_SPR))
        else $error("mark changed outside a restart");
`endif

endmodule

[rtl/fec_repair_trigger_decider_unit.sv]
// Top level of the repair trigger decider: configuration registers, result
// register and channel handshakes. Depends on frdu_pkg, frdu_if, frdu_seq, frdu_div.
//
// Each input word is one send opportunity; the block answers with one result
// word whose send_repair bit says whether to emit a repair symbol now. Items
// are handled one at a time: item_in.ready is high only while the sequencer
// is idle. All divisions run one quotient bit per cycle through a single
// shared divider. An item takes one 36-bit division when the budget
// check refuses, one 36-bit and one 20-bit division for a decision on the
// current protection mark or for too few unprotected packets, one 36-bit,
// two 20-bit and one 52-bit division when protection restarts at a new
// window end, and one 36-bit, one 20-bit and one 52-bit division on a
// restart whose burst term is skipped. The result word shows up in the
// same cycle in which the next word can be taken. The finished result
// sits in an output register, so the next item is accepted while the
// previous result waits to be taken; a result that finds that register
// still full holds the sequencer until it drains.
// Registers: index 0 loss_granularity and index 1 fixed_scale, both 20 bits
// and reset to 1000000; a zero acts as one. Write them only while the block is
// idle; cfg.ready is always high and writes to other indexes are ignored.
// Protection state (mark, repair count, trigger limit) clears on reset; the
// repair count and the limit saturate.
module fec_repair_trigger_decider_unit
    import frdu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    frdu_item_if.sink  item_in,
    frdu_result_if.source result_out,
    frdu_cfg_if.sink   cfg
);

    logic [ScaleW-1:0] gran_reg, gran_next;
    logic [ScaleW-1:0] fscale_reg, fscale_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_send_reg, out_send_next;

    frdu_item_t    item;
    frdu_div_req_t div_req;
    frdu_div_rsp_t div_rsp;
    logic          item_ready;
    logic          res_free;
    logic          res_load;
    logic          res_send;
    logic          cfg_fire;
    logic          out_fire;

    // Pack the input word for the sequencer
    assign item.window_end        = item_in.window_end;
    assign item.window_len        = item_in.window_len;
    assign item.repairs_in_flight = item_in.repairs_in_flight;
    assign item.uniform_loss      = item_in.uniform_loss;
    assign item.burst_enter_p     = item_in.burst_enter_p;
    assign item.burst_leave_r     = item_in.burst_leave_r;
    assign item.flow_blocked      = item_in.flow_blocked;
    assign item_in.ready          = item_ready;

    // Configuration: take a write at any time, drop unknown indexes
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_comb
    begin
        gran_next   = gran_reg;
        fscale_next = fscale_reg;
        if (cfg_fire)
        begin
            case (cfg.index)
                CFG_LOSS_GRANULARITY: gran_next   = cfg.data;
                CFG_FIXED_SCALE:      fscale_next = cfg.data;
                default:              gran_next   = gran_reg;
            endcase
        end
    end

    // Result register: free when empty or being taken this cycle
    assign out_fire = out_valid_reg && result_out.ready;
    assign res_free = !out_valid_reg || result_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_send_next  = out_send_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_send_next  = res_send;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.send_repair = out_send_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gran_reg      <= SCALE_RESET;
            fscale_reg    <= SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gran_reg      <= gran_next;
            fscale_reg    <= fscale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_send_reg <= out_send_next;
    end

    frdu_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_in.valid),
        .item_ready (item_ready),
        .gran_eff   (at_least_one(gran_reg)),
        .fscale_eff (at_least_one(fscale_reg)),
        .fscale_raw (fscale_reg),
        .res_free   (res_free),
        .res_load   (res_load),
        .res_send   (res_send),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    frdu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_ready) |=> !item_ready)
        else $error("input taken again right after an accepted word");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> res_free)
        else $error("result loaded over a pending word");

    a_no_load_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !item_ready)
        else $error("result produced while idle");
`endif

endmodule
